// File: design/bbsa_pkg.sv
// Shared types, constants and helpers for the bracketed bitmap slot allocator.
// Used by every module in the design folder; depends on nothing.
`default_nettype none

package bbsa_pkg;

    // Fixed geometry of one occupancy block.
    localparam int SLOTS_PER_BLOCK = 64;
    localparam int SLOT_W          = 6;
    localparam int WORD_W          = SLOTS_PER_BLOCK;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int BR_W     = 2;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 4;
    localparam int CAP_W    = 10;

    // Configuration registers.
    localparam int NUM_CFG   = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd64;

    // Defaults for the top-level parameters.
    localparam int NUM_BRACKETS_DEF = 4;
    localparam int MAX_BLOCKS_DEF   = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WIPE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [BR_W-1:0]     bracket;
        logic [OFFSET_W-1:0] slot_offset;
        logic [COUNT_W-1:0]  shape_count;
    } req_t;

    typedef struct packed {
        logic                done_ok;
        logic [BR_W-1:0]     result_bracket;
        logic [OFFSET_W-1:0] result_offset;
        logic [COUNT_W-1:0]  result_count;
    } rsp_t;

    // Result of the zero-bit finder on one byte lane of a bitmap word.
    typedef struct packed {
        logic       hit;
        logic [2:0] pos;
    } find_t;

    // Shape offset of a slot: (block * 64 + slot) shifted left by the bracket.
    function automatic logic [OFFSET_W-1:0] slot_to_offset(
        input logic [SLOT_W-1:0] blk,
        input logic [SLOT_W-1:0] slot,
        input logic [BR_W-1:0]   br
    );
        logic [OFFSET_W-1:0] base;
        base = {blk, slot};
        return OFFSET_W'(base << br);
    endfunction

endpackage

`default_nettype wire

// File: design/bbsa_zero_find.sv
// Finds the lowest clear bit in one selected byte lane of a 64-bit bitmap word.
// Depends on bbsa_pkg for the word width and the find_t result type.
`default_nettype none

module bbsa_zero_find
    import bbsa_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [2:0]        lane,
    output find_t                  found
);

    logic [7:0] lane_bits;

    assign lane_bits = word[{lane, 3'b000} +: 8];

    // Scan from the top so that the lowest clear bit wins.
    always_comb
    begin
        found = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!lane_bits[k])
            begin
                found.hit = 1'b1;
                found.pos = 3'(k);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/bbsa_bitmap_ram.sv
// Occupancy bitmap store: one write port and one read port with registered data.
// Depends on bbsa_pkg for the word width.
`default_nettype none

module bbsa_bitmap_ram
    import bbsa_pkg::*;
#(
    parameter int AW = 5
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/bracketed_bitmap_slot_allocator.sv
// Bracketed bitmap slot allocator: sequencer, block counts and configuration.
// Depends on bbsa_pkg, bbsa_bitmap_ram and bbsa_zero_find.
//
// Usage. A request word enters on req when req_valid is high and req_stall is low.
// Exactly one response word leaves on rsp per request; it is taken when rsp_valid
// is high and rsp_stall is low. The block works on one request at a time.
// Steps from acceptance to rsp_valid, with D = 2**(BW+KW) bitmap words (32 at
// the default parameters):
//   allocate: the block scan reads the bracket's bitmap words in turn from the
//             single RAM read port until one is not full, then the bit search
//             checks one byte per cycle, from the lowest lane up, for the free
//             slot. With every block in use full, a new block is appended, or
//             the request fails when MAX_BLOCKS blocks are full.
//   clear:    the word is read, the slot's bit cleared and written back.
//             An offset outside the bracket skips both.
//   reset bitmaps and init: all D RAM words are cleared, one per cycle.
// A new request is taken as soon as the previous one has reached the output
// register, even while that response is still stalled; if the receiver keeps
// stalling, the next response waits in the sequencer and req_stall stays high.
// After rst_n is released the block clears all D bitmap words, one per cycle,
// and holds req_stall high meanwhile. Configuration writes on cfg_we,
// cfg_index and cfg_data are taken in any cycle and are meant for idle periods;
// block counts are zero after reset, grow on allocate and are reloaded by init.
`default_nettype none

module bracketed_bitmap_slot_allocator
    import bbsa_pkg::*;
#(
    parameter int NUM_BRACKETS = NUM_BRACKETS_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_t                 req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAP_W-1:0]     cfg_data
);

    // Widths that follow from the parameters.
    localparam int BW   = (NUM_BRACKETS > 1) ? $clog2(NUM_BRACKETS) : 1;
    localparam int KW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int AW   = BW + KW;
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_ATEST = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_CRD   = 3'd5;
    localparam logic [2:0] S_CWR   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          state_reg,  state_next;
    logic [AW-1:0]       sweep_reg,  sweep_next;
    logic                pend_reg,   pend_next;
    logic [BR_W-1:0]     br_reg,     br_next;
    logic [COUNT_W-1:0]  cnt_reg,    cnt_next;
    logic [CW-1:0]       blk_reg,    blk_next;
    logic [CW-1:0]       n_reg,      n_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [2:0]          lane_reg,   lane_next;
    logic [WORD_W-1:0]   word_reg,   word_next;
    logic                ok_reg,     ok_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,    rsp_next;
    logic [CW-1:0]       blocks_reg  [NUM_BRACKETS];
    logic [CW-1:0]       blocks_next [NUM_BRACKETS];
    logic [CAP_W-1:0]    cfg_reg     [NUM_CFG];
    logic [CW-1:0]       init_cnt    [NUM_BRACKETS];

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_addr;
    logic [WORD_W-1:0]   mem_rdata;
    find_t               found;

    logic [BW-1:0]       req_idx;
    logic [BW-1:0]       cur_idx;
    logic                req_br_ok;
    logic [SLOT_W-1:0]   clr_blk;
    logic [SLOT_W-1:0]   clr_slot;
    logic [SLOT_W-1:0]   hit_slot;

    // ------------------------------------------------------------------
    // Configuration registers: start capacity per bracket.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CAP_RESET;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Block count that init gives each bracket: capacity rounded up to whole
    // blocks and saturated at the maximum. Brackets without a register get zero.
    for (genvar b = 0; b < NUM_BRACKETS; b++)
    begin : g_init
        if (b < NUM_CFG)
        begin : g_cfg
            logic [CAP_W:0]        cap_sum;
            logic [CAP_W-SLOT_W:0] cap_blocks;
            assign cap_sum    = {1'b0, cfg_reg[b]} + (CAP_W+1)'(SLOTS_PER_BLOCK - 1);
            assign cap_blocks = cap_sum[CAP_W:SLOT_W];
            assign init_cnt[b] = (32'(cap_blocks) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                                 : CW'(cap_blocks);
        end
        else
        begin : g_zero
            assign init_cnt[b] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Bitmap store and the shared zero-bit finder.
    // ------------------------------------------------------------------
    assign cur_idx  = BW'(br_reg);
    assign mem_addr = {cur_idx, blk_reg[KW-1:0]};

    bbsa_bitmap_ram #(
        .AW (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    bbsa_zero_find u_find (
        .word  (word_reg),
        .lane  (lane_reg),
        .found (found)
    );

    assign hit_slot = {lane_reg, found.pos};

    // Request decode: bracket index, and block and slot of a clear offset.
    assign req_idx   = BW'(req.bracket);
    assign req_br_ok = (32'(req.bracket) < NUM_BRACKETS);
    assign clr_blk   = SLOT_W'(req.slot_offset >> (4'(SLOT_W) + 4'(req.bracket)));
    assign clr_slot  = SLOT_W'(req.slot_offset >> req.bracket);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        br_next        = br_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        n_next         = n_reg;
        slot_next      = slot_reg;
        lane_next      = lane_reg;
        word_next      = word_reg;
        ok_next        = ok_reg;
        offset_next    = offset_reg;
        rsp_next       = rsp_reg;
        blocks_next    = blocks_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = mem_addr;
        mem_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    br_next     = req.bracket;
                    ok_next     = 1'b1;
                    offset_next = '0;
                    cnt_next    = (req.command == CMD_ALLOC) ? req.shape_count : '0;
                    state_next  = S_DONE;
                    case (req.command)
                        CMD_ALLOC:
                        begin
                            if (!req_br_ok)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                n_next     = blocks_reg[req_idx];
                                blk_next   = '0;
                                state_next = S_ARD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            // Offsets beyond the bracket's block count are ignored.
                            if (req_br_ok &&
                                (CMPW'(clr_blk) < CMPW'(blocks_reg[req_idx])))
                            begin
                                blk_next   = CW'(clr_blk);
                                slot_next  = clr_slot;
                                state_next = S_CRD;
                            end
                        end
                        CMD_WIPE:
                        begin
                            sweep_next = '0;
                            pend_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            blocks_next = init_cnt;
                            sweep_next  = '0;
                            pend_next   = 1'b1;
                            state_next  = S_CLEAR;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == '1)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            S_ARD:
            begin
                if (blk_reg == n_reg)
                begin
                    // Every block in use is full: if there is room, append a fresh block, whose
                    // word is already zero, and take its first slot; else fail.
                    if (32'(n_reg) < MAX_BLOCKS)
                    begin
                        mem_we                = 1'b1;
                        mem_wdata             = WORD_W'(1);
                        blocks_next[cur_idx]  = n_reg + 1'b1;
                        offset_next = slot_to_offset(SLOT_W'(blk_reg), '0, br_reg);
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ATEST;
                end
            end

            S_ATEST:
            begin
                if (mem_rdata != '1)
                begin
                    word_next  = mem_rdata;
                    lane_next  = '0;
                    state_next = S_FIND;
                end
                else
                begin
                    blk_next   = blk_reg + 1'b1;
                    state_next = S_ARD;
                end
            end

            S_FIND:
            begin
                if (found.hit)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = word_reg | (WORD_W'(1) << hit_slot);
                    offset_next = slot_to_offset(SLOT_W'(blk_reg), hit_slot, br_reg);
                    state_next  = S_DONE;
                end
                else
                begin
                    lane_next = lane_reg + 1'b1;
                end
            end

            S_CRD:
            begin
                state_next = S_CWR;
            end

            S_CWR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata & ~(WORD_W'(1) << slot_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.done_ok        = ok_reg;
                    rsp_next.result_bracket = br_reg;
                    rsp_next.result_offset  = offset_reg;
                    rsp_next.result_count   = cnt_reg;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BRACKETS; i++)
            begin
                blocks_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            blocks_reg    <= blocks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg     <= br_next;
        cnt_reg    <= cnt_next;
        blk_reg    <= blk_next;
        n_reg      <= n_next;
        slot_reg   <= slot_next;
        lane_reg   <= lane_next;
        word_reg   <= word_next;
        ok_reg     <= ok_next;
        offset_reg <= offset_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A response word only appears right after the sequencer finished a request.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("response word raised outside the done state");

    // The bit search only runs on a word that has a free slot.
    a_find_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIND |-> word_reg != '1)
        else $error("bit search started on a full bitmap word");

    // The lane counter never runs past the last byte without a hit.
    a_find_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIND && !found.hit |=> lane_reg != 3'd0)
        else $error("bit search wrapped without finding a free slot");

endmodule

`default_nettype wire

// File: sim/tb_bracketed_bitmap_slot_allocator.sv
// Self-checking testbench for the bracketed bitmap slot allocator.
// Depends on bbsa_pkg and the design top level; an internal allocator model predicts each word.

module tb_bracketed_bitmap_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bbsa_pkg::*;

    localparam int NBR            = NUM_BRACKETS_DEF;
    localparam int MAXB           = MAX_BLOCKS_DEF;
    localparam int DIR_N          = 21;
    // The longest quiet stretches of a correct run are a solid receiver stall, a wipe,
    // a sender gap and the final drain, all well under this limit.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int FILL_ALLOCS    = 520;

    // One row of the directed table: the request word, and the response word typed
    // in by hand where it is obvious. Rows with fixed low take the model's answer.
    typedef struct packed {
        req_t w;
        logic fixed;
        rsp_t want;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req_word  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp_word;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAP_W-1:0]     cfg_data  = '0;

    bracketed_bitmap_slot_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the allocator: occupancy bitmaps, block counts per bracket and
    // the start capacity registers. It is updated at the edge where a word is taken.
    logic [WORD_W-1:0] occ_map [NBR][MAXB];
    int                blk_cnt [NBR];
    logic [CAP_W-1:0]  cap_reg [NUM_CFG];

    rsp_t     pending_rsp [$];
    dir_row_t dir_table [DIR_N];

    logic     row_fixed   = 1'b0;
    rsp_t     row_want    = '0;
    int       idle_cycles = 0;
    int       err_count   = 0;
    int       words_out   = 0;
    int       burst_left  = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("MISMATCH at response %0d: %s got 0x%0h expected 0x%0h",
                 words_out, what, got_v, want_v);
        err_count++;
    endtask

    task automatic compare_word(input rsp_t got, input rsp_t want);
        if (got.done_ok !== want.done_ok)
            report_mismatch("done_ok", 32'(got.done_ok), 32'(want.done_ok));
        if (got.result_bracket !== want.result_bracket)
            report_mismatch("result_bracket", 32'(got.result_bracket),
                            32'(want.result_bracket));
        if (got.result_offset !== want.result_offset)
            report_mismatch("result_offset", 32'(got.result_offset),
                            32'(want.result_offset));
        if (got.result_count !== want.result_count)
            report_mismatch("result_count", 32'(got.result_count),
                            32'(want.result_count));
    endtask

    task automatic wipe_bitmaps();
        for (int b = 0; b < NBR; b++)
            for (int k = 0; k < MAXB; k++)
                occ_map[b][k] = '0;
    endtask

    // Applies one request word to the shadow state and returns the response word
    // the block must give for it.
    task automatic alloc_step(input req_t w, output rsp_t r);
        int   b;
        int   n;
        int   sel;
        int   bit_pos;
        int   span;
        int   blk;
        int   blocks;
        logic found;
        b        = int'(w.bracket);
        r        = '0;
        r.done_ok        = 1'b1;
        r.result_bracket = w.bracket;
        case (w.command)
            CMD_ALLOC:
            begin
                r.result_count = w.shape_count;
                n     = blk_cnt[b];
                found = 1'b0;
                sel   = 0;
                // First fit: lowest block that still has a free slot.
                for (int k = 0; k < n; k++)
                    if (!found && occ_map[b][k] != '1)
                    begin
                        found = 1'b1;
                        sel   = k;
                    end
                // Every block in use is full: append a cleared one if there is room.
                if (!found)
                begin
                    if (n < MAXB)
                    begin
                        sel           = n;
                        occ_map[b][n] = '0;
                        blk_cnt[b]    = n + 1;
                        found         = 1'b1;
                    end
                    else
                        r.done_ok = 1'b0;
                end
                if (found)
                begin
                    bit_pos = 0;
                    for (int k = SLOTS_PER_BLOCK - 1; k >= 0; k--)
                        if (!occ_map[b][sel][k])
                            bit_pos = k;
                    occ_map[b][sel][bit_pos] = 1'b1;
                    r.result_offset = OFFSET_W'((sel * SLOTS_PER_BLOCK + bit_pos) << b);
                end
            end
            CMD_CLEAR:
            begin
                span    = SLOTS_PER_BLOCK << b;
                blk     = int'(w.slot_offset) / span;
                bit_pos = ((int'(w.slot_offset) % span) >> b) & (SLOTS_PER_BLOCK - 1);
                // A block beyond the bracket's count is silently ignored.
                if (blk < blk_cnt[b] && blk < MAXB)
                    occ_map[b][blk][bit_pos] = 1'b0;
            end
            CMD_WIPE:
                wipe_bitmaps();
            default:
            begin
                // Init: round each capacity up to whole blocks, saturating at the maximum.
                wipe_bitmaps();
                for (int i = 0; i < NBR; i++)
                begin
                    blocks = (i < NUM_CFG) ?
                             (int'(cap_reg[i]) + SLOTS_PER_BLOCK - 1) / SLOTS_PER_BLOCK : 0;
                    blk_cnt[i] = (blocks > MAXB) ? MAXB : blocks;
                end
            end
        endcase
    endtask

    // Samples both channels and the configuration port at every rising edge. The
    // response side is checked first, since a word taken at this edge cannot have
    // its answer at the same edge.
    always @(posedge clk)
    begin
        rsp_t predicted;
        rsp_t oldest;
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we && int'(cfg_index) < NUM_CFG)
                cap_reg[cfg_index] = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                if (pending_rsp.size() == 0)
                    report_mismatch("response word with nothing pending", 32'(rsp_word), 0);
                else
                begin
                    oldest = pending_rsp.pop_front();
                    compare_word(rsp_word, oldest);
                end
                words_out++;
            end
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                alloc_step(req_word, predicted);
                if (row_fixed)
                    predicted = row_want;
                pending_rsp.push_back(predicted);
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver stalls on a pattern of its own: runs of no stall, coin-flip
    // stalls, light stalls and solid stalls, each of random length.
    initial
    begin
        int mode;
        int len;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, (mode == 2) ? 40 : 60);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= 1'($urandom_range(0, 1));
                    2:       rsp_stall <= 1'b1;
                    default: rsp_stall <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Presents one request word at a falling edge and holds it until it is taken.
    // The sender works in bursts; when a burst runs out it idles before the next one.
    task automatic issue(input req_t w, input logic fixed, input rsp_t want);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        req_word  <= w;
        row_fixed <= fixed;
        row_want  <= want;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_caps(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                              input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3);
        logic [CAP_W-1:0] caps [NUM_CFG];
        caps[0] = c0;
        caps[1] = c1;
        caps[2] = c2;
        caps[3] = c3;
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= caps[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Picks the shape offset of a slot that is in use, starting the search at a
    // random place, and fills the bits below the slot size with junk that the block
    // must ignore. With nothing in use it falls back to any offset.
    function automatic logic [OFFSET_W-1:0] live_offset(input int b);
        int               total;
        int               start;
        int               pos;
        int               hit;
        logic [OFFSET_W-1:0] low;
        total = blk_cnt[b] * SLOTS_PER_BLOCK;
        hit   = -1;
        if (total == 0)
            return OFFSET_W'($urandom_range(0, 4095));
        start = $urandom_range(0, total - 1);
        for (int i = 0; i < total; i++)
        begin
            pos = (start + i) % total;
            if (hit < 0 && occ_map[b][pos / SLOTS_PER_BLOCK][pos % SLOTS_PER_BLOCK])
                hit = pos;
        end
        if (hit < 0)
            return OFFSET_W'($urandom_range(0, 4095));
        low = OFFSET_W'($urandom_range(0, (1 << b) - 1));
        return OFFSET_W'((hit << b) | int'(low));
    endfunction

    // Random request mix: mostly allocates and clears of live slots, aimed at one
    // focus bracket so that blocks pile up, with stray clears, wipes and inits.
    task automatic random_word(input int focus, output req_t w);
        int pick;
        pick          = $urandom_range(0, 99);
        w.bracket     = ($urandom_range(0, 9) < 7) ? BR_W'(focus) : BR_W'($urandom_range(0, 3));
        w.slot_offset = OFFSET_W'($urandom_range(0, 4095));
        w.shape_count = COUNT_W'($urandom_range(0, 15));
        if (pick < 60)
            w.command = CMD_ALLOC;
        else if (pick < 85)
        begin
            w.command     = CMD_CLEAR;
            w.slot_offset = live_offset(int'(w.bracket));
        end
        else if (pick < 95)
            w.command = CMD_CLEAR;
        else if (pick < 98)
            w.command = CMD_WIPE;
        else
            w.command = CMD_INIT;
    endtask

    // One phase: wait until the block is idle, load new capacities, init, then a
    // stream of words. A fill phase first runs one bracket into its block limit.
    task automatic run_phase(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                             input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3,
                             input int count, input int fill_br);
        req_t w;
        int   focus;
        wait_idle();
        write_caps(c0, c1, c2, c3);
        w.command     = CMD_INIT;
        w.bracket     = BR_W'($urandom_range(0, 3));
        w.slot_offset = OFFSET_W'($urandom_range(0, 4095));
        w.shape_count = COUNT_W'($urandom_range(0, 15));
        issue(w, 1'b0, '0);
        focus = (fill_br >= 0) ? fill_br : $urandom_range(0, NBR - 1);
        for (int i = 0; i < count; i++)
        begin
            random_word(focus, w);
            if (fill_br >= 0 && i < FILL_ALLOCS)
            begin
                w.command = CMD_ALLOC;
                w.bracket = BR_W'(fill_br);
            end
            issue(w, 1'b0, '0);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] fill_caps [NUM_CFG];
        int               fill_br;

        // Shadow state after reset: empty bitmaps, no blocks, capacities at 64.
        wipe_bitmaps();
        for (int i = 0; i < NBR; i++)
            blk_cnt[i] = 0;
        for (int i = 0; i < NUM_CFG; i++)
            cap_reg[i] = CAP_RESET;

        // Directed words, run with the reset capacities. Columns: command, bracket,
        // offset, count, then whether a response is typed in and the response itself.
        // No bracket has a block yet, so the first allocate must append one.
        dir_table[0]  = {CMD_ALLOC, 2'd0, 12'd0,    4'd8,  1'b1, 1'b1, 2'd0, 12'd0, 4'd8};
        dir_table[1]  = {CMD_ALLOC, 2'd3, 12'd4095, 4'd15, 1'b1, 1'b1, 2'd3, 12'd0, 4'd15};
        dir_table[2]  = {CMD_ALLOC, 2'd0, 12'd0,    4'd0,  1'b0, 19'd0};
        // Clear past the block count is ignored.
        dir_table[3]  = {CMD_CLEAR, 2'd0, 12'd4095, 4'd15, 1'b1, 1'b1, 2'd0, 12'd0, 4'd0};
        dir_table[4]  = {CMD_CLEAR, 2'd0, 12'd0,    4'd0,  1'b1, 1'b1, 2'd0, 12'd0, 4'd0};
        // Clearing the same slot again finds it already free.
        dir_table[5]  = {CMD_CLEAR, 2'd0, 12'd0,    4'd0,  1'b1, 1'b1, 2'd0, 12'd0, 4'd0};
        dir_table[6]  = {CMD_ALLOC, 2'd0, 12'd0,    4'd3,  1'b0, 19'd0};
        dir_table[7]  = {CMD_ALLOC, 2'd1, 12'd0,    4'd1,  1'b0, 19'd0};
        dir_table[8]  = {CMD_ALLOC, 2'd1, 12'd0,    4'd2,  1'b0, 19'd0};
        // Offset 3 in the two-shape bracket lands in the slot that starts at 2.
        dir_table[9]  = {CMD_CLEAR, 2'd1, 12'd3,    4'd0,  1'b1, 1'b1, 2'd1, 12'd0, 4'd0};
        dir_table[10] = {CMD_ALLOC, 2'd1, 12'd0,    4'd7,  1'b0, 19'd0};
        dir_table[11] = {CMD_ALLOC, 2'd2, 12'd0,    4'd4,  1'b0, 19'd0};
        dir_table[12] = {CMD_WIPE,  2'd2, 12'd4095, 4'd15, 1'b1, 1'b1, 2'd2, 12'd0, 4'd0};
        dir_table[13] = {CMD_ALLOC, 2'd0, 12'd0,    4'd5,  1'b0, 19'd0};
        dir_table[14] = {CMD_INIT,  2'd1, 12'd4095, 4'd15, 1'b1, 1'b1, 2'd1, 12'd0, 4'd0};
        dir_table[15] = {CMD_ALLOC, 2'd3, 12'd0,    4'd8,  1'b1, 1'b1, 2'd3, 12'd0, 4'd8};
        dir_table[16] = {CMD_CLEAR, 2'd3, 12'd0,    4'd0,  1'b1, 1'b1, 2'd3, 12'd0, 4'd0};
        dir_table[17] = {CMD_CLEAR, 2'd2, 12'd2047, 4'd0,  1'b1, 1'b1, 2'd2, 12'd0, 4'd0};
        dir_table[18] = {CMD_ALLOC, 2'd2, 12'd0,    4'd15, 1'b0, 19'd0};
        dir_table[19] = {CMD_WIPE,  2'd0, 12'd0,    4'd0,  1'b1, 1'b1, 2'd0, 12'd0, 4'd0};
        dir_table[20] = {CMD_INIT,  2'd3, 12'd0,    4'd0,  1'b1, 1'b1, 2'd3, 12'd0, 4'd0};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            issue(dir_table[i].w, dir_table[i].fixed, dir_table[i].want);

        // Zero capacity everywhere: every bracket starts empty and grows on demand.
        run_phase(10'd0, 10'd0, 10'd0, 10'd0, 150, -1);

        // One bracket is driven past its block limit, starting either fully sized
        // or from nothing; the tail then punches holes and refills them.
        fill_br = $urandom_range(0, NBR - 1);
        for (int i = 0; i < NUM_CFG; i++)
            fill_caps[i] = CAP_W'($urandom_range(0, 1023));
        fill_caps[fill_br] = $urandom_range(0, 1) ? 10'd512 : 10'd0;
        run_phase(fill_caps[0], fill_caps[1], fill_caps[2], fill_caps[3],
                  FILL_ALLOCS + 60, fill_br);

        run_phase(CAP_W'($urandom_range(0, 1023)), CAP_W'($urandom_range(0, 1023)),
                  CAP_W'($urandom_range(0, 1023)), CAP_W'($urandom_range(0, 1023)),
                  270, -1);
        // Capacities on both sides of a block boundary.
        run_phase(10'd1, 10'd64, 10'd65, 10'd511, 270, -1);
        // All ones: the block count saturates at the maximum.
        run_phase(10'd1023, 10'd1023, 10'd1023, 10'd1023, 270, -1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_rsp.size() != 0)
            report_mismatch("responses never returned", 0, pending_rsp.size());

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
